// File: rtl/lrci_pkg.sv
// Shared types and constants for the line rasterizer with color interpolation.
package lrci_pkg;

  localparam int COORD_BITS_DEF   = 12;
  localparam int CHAN_BITS        = 8;
  localparam int NUM_CHAN         = 4;
  localparam int COLOR_BITS       = CHAN_BITS * NUM_CHAN;
  localparam int DIV_BITS_PER_CYC = 2;
  localparam int DIV_CYCLES       = CHAN_BITS / DIV_BITS_PER_CYC;
  localparam int DIV_CNT_W        = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  typedef struct packed {
    logic load;       // capture endpoints, order by x
    logic delta;      // compute |dx|, |dy|
    logic setup;      // pick major axis, start point, decision term
    logic num_init;   // load color numerators
    logic div_start;  // load divider lanes
    logic div_step;   // one divider iteration group
    logic emit;       // capture result, advance walk
  } lrci_cmd_t;

  typedef struct packed {
    logic busy;
  } lrci_stat_t;

endpackage

// File: rtl/lrci_if.sv
// Valid/ready channel interfaces for line commands and pixel results.
interface lrci_in_if #(parameter int COORD_BITS = lrci_pkg::COORD_BITS_DEF);
  import lrci_pkg::*;
  logic                         valid;
  logic                         ready;
  logic                         mode;
  logic signed [COORD_BITS-1:0] x_start;
  logic signed [COORD_BITS-1:0] y_start;
  logic signed [COORD_BITS-1:0] x_end;
  logic signed [COORD_BITS-1:0] y_end;
  logic [COLOR_BITS-1:0]        first_color;
  logic [COLOR_BITS-1:0]        second_color;

  modport source(output valid, mode, x_start, y_start, x_end, y_end,
                        first_color, second_color,
                 input ready);
  modport sink(input valid, mode, x_start, y_start, x_end, y_end,
                     first_color, second_color,
               output ready);
endinterface

interface lrci_out_if #(parameter int COORD_BITS = lrci_pkg::COORD_BITS_DEF);
  import lrci_pkg::*;
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] pixel_x;
  logic signed [COORD_BITS-1:0] pixel_y;
  logic [COLOR_BITS-1:0]        pixel_color;
  logic                         write_enable;
  logic                         last;

  modport source(output valid, pixel_x, pixel_y, pixel_color, write_enable, last,
                 input ready);
  modport sink(input valid, pixel_x, pixel_y, pixel_color, write_enable, last,
               output ready);
endinterface

// File: rtl/lrci_ctrl.sv
// Sequencer for line load, color division and pixel emission.
module lrci_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_mode,
  input  logic               out_free,
  input  lrci_pkg::lrci_stat_t stat,
  output logic               in_ready,
  output lrci_pkg::lrci_cmd_t  cmd
);
  import lrci_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_LD_DELTA = 3'd1;
  localparam logic [2:0] ST_LD_SETUP = 3'd2;
  localparam logic [2:0] ST_LD_NUM   = 3'd3;
  localparam logic [2:0] ST_DIV      = 3'd4;
  localparam logic [2:0] ST_EMIT     = 3'd5;

  logic [2:0]           state;
  logic [2:0]           state_next;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_CNT_W-1:0] cnt_next;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (!in_mode) begin
            cmd.load   = 1'b1;
            state_next = ST_LD_DELTA;
          end else if (stat.busy) begin
            cmd.div_start = 1'b1;
            cnt_next      = '0;
            state_next    = ST_DIV;
          end
        end
      end
      ST_LD_DELTA: begin
        cmd.delta  = 1'b1;
        state_next = ST_LD_SETUP;
      end
      ST_LD_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = ST_LD_NUM;
      end
      ST_LD_NUM: begin
        cmd.num_init = 1'b1;
        state_next   = ST_IDLE;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          state_next = ST_EMIT;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

endmodule

// File: rtl/lrci_walk.sv
// Midpoint line walker: endpoint ordering, decision term and pixel position.
module lrci_walk #(
  parameter int COORD_BITS = lrci_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lrci_pkg::lrci_cmd_t          cmd,
  input  logic signed [COORD_BITS-1:0] x_start,
  input  logic signed [COORD_BITS-1:0] y_start,
  input  logic signed [COORD_BITS-1:0] x_end,
  input  logic signed [COORD_BITS-1:0] y_end,
  output lrci_pkg::lrci_stat_t         stat,
  output logic signed [COORD_BITS-1:0] cur_x,
  output logic signed [COORD_BITS-1:0] cur_y,
  output logic [COORD_BITS:0]          span,
  output logic                         last,
  output logic                         color_rev
);
  import lrci_pkg::*;

  localparam int SPAN_W = COORD_BITS + 1;
  localparam int DEC_W  = COORD_BITS + 3;

  logic signed [COORD_BITS-1:0] x1, y1, x2, y2;
  logic                         x_swap;
  logic [SPAN_W-1:0]            abs_dx, abs_dy;
  logic                         dy_neg;
  logic signed [DEC_W-1:0]      decision;
  logic [SPAN_W-1:0]            step_index;
  logic                         steep;
  logic                         busy;

  logic                         swap_in;
  logic signed [SPAN_W-1:0]     dx_w, dy_w;
  logic                         x_major;
  logic                         rev_start;
  logic signed [DEC_W-1:0]      adx_s, ady_s;
  logic [SPAN_W:0]              k_inc;

  assign swap_in   = x_start > x_end;
  assign dx_w      = {x2[COORD_BITS-1], x2} - {x1[COORD_BITS-1], x1};
  assign dy_w      = {y2[COORD_BITS-1], y2} - {y1[COORD_BITS-1], y1};
  assign x_major   = (abs_dx != '0) && (dy_neg ? (abs_dy < abs_dx) : (abs_dy <= abs_dx));
  assign rev_start = !x_major && dy_neg;
  assign adx_s     = signed'(DEC_W'(abs_dx));
  assign ady_s     = signed'(DEC_W'(abs_dy));
  assign k_inc     = {1'b0, step_index} + 1'b1;
  assign last      = k_inc >= {1'b0, span};
  assign stat.busy = busy;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_swap <= swap_in;
      x1     <= swap_in ? x_end   : x_start;
      y1     <= swap_in ? y_end   : y_start;
      x2     <= swap_in ? x_start : x_end;
      y2     <= swap_in ? y_start : y_end;
    end
    if (cmd.delta) begin
      abs_dx <= dx_w;
      dy_neg <= dy_w[SPAN_W-1];
      abs_dy <= dy_w[SPAN_W-1] ? -dy_w : dy_w;
    end
    if (cmd.setup) begin
      steep      <= !x_major;
      cur_x      <= rev_start ? x2 : x1;
      cur_y      <= rev_start ? y2 : y1;
      color_rev  <= x_swap ^ rev_start;
      decision   <= x_major ? (adx_s - (ady_s <<< 1)) : (ady_s - (adx_s <<< 1));
      span       <= x_major ? abs_dx : abs_dy;
      step_index <= '0;
    end
    if (cmd.emit) begin
      step_index <= k_inc[SPAN_W-1:0];
      if (!steep) begin
        cur_x <= cur_x + 1'b1;
        if (decision <= 0) begin
          cur_y    <= dy_neg ? cur_y - 1'b1 : cur_y + 1'b1;
          decision <= decision + ((adx_s - ady_s) <<< 1);
        end else begin
          decision <= decision - (ady_s <<< 1);
        end
      end else begin
        cur_y <= cur_y + 1'b1;
        if (decision <= 0) begin
          cur_x    <= dy_neg ? cur_x - 1'b1 : cur_x + 1'b1;
          decision <= decision + ((ady_s - adx_s) <<< 1);
        end else begin
          decision <= decision - (adx_s <<< 1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (cmd.setup) begin
      busy <= x_major ? (abs_dx != '0) : (abs_dy != '0);
    end else if (cmd.emit && last) begin
      busy <= 1'b0;
    end
  end

endmodule

// File: rtl/lrci_color.sv
// Per-channel color numerators and four radix-4 restoring divider lanes.
module lrci_color #(
  parameter int COORD_BITS = lrci_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  lrci_pkg::lrci_cmd_t             cmd,
  input  logic [lrci_pkg::COLOR_BITS-1:0] first_color,
  input  logic [lrci_pkg::COLOR_BITS-1:0] second_color,
  input  logic [COORD_BITS:0]             span,
  input  logic                            color_rev,
  output logic [lrci_pkg::COLOR_BITS-1:0] color
);
  import lrci_pkg::*;

  localparam int SPAN_W = COORD_BITS + 1;
  localparam int NUM_W  = CHAN_BITS + SPAN_W;

  logic [COLOR_BITS-1:0]       c_start, c_end;
  logic [COLOR_BITS-1:0]       lo_col, hi_col;
  logic [NUM_W-1:0]            num   [NUM_CHAN];
  logic signed [CHAN_BITS:0]   delta [NUM_CHAN];
  logic [SPAN_W-1:0]           rem   [NUM_CHAN];
  logic [CHAN_BITS-1:0]        quo   [NUM_CHAN];
  logic [SPAN_W-1:0]           rem_next [NUM_CHAN];
  logic [CHAN_BITS-1:0]        quo_next [NUM_CHAN];

  assign lo_col = color_rev ? c_end   : c_start;
  assign hi_col = color_rev ? c_start : c_end;

  always_comb begin
    logic [SPAN_W-1:0]    r;
    logic [CHAN_BITS-1:0] q;
    logic [SPAN_W:0]      t;
    logic                 ge;
    for (int c = 0; c < NUM_CHAN; c++) begin
      r = rem[c];
      q = quo[c];
      for (int j = 0; j < DIV_BITS_PER_CYC; j++) begin
        t  = {r, q[CHAN_BITS-1]};
        ge = t >= {1'b0, span};
        r  = ge ? SPAN_W'(t - {1'b0, span}) : t[SPAN_W-1:0];
        q  = {q[CHAN_BITS-2:0], ge};
      end
      rem_next[c] = r;
      quo_next[c] = q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_start <= first_color;
      c_end   <= second_color;
    end
    for (int c = 0; c < NUM_CHAN; c++) begin
      if (cmd.num_init) begin
        num[c]   <= NUM_W'(lo_col[c*CHAN_BITS +: CHAN_BITS]) * NUM_W'(span);
        delta[c] <= signed'({1'b0, hi_col[c*CHAN_BITS +: CHAN_BITS]})
                  - signed'({1'b0, lo_col[c*CHAN_BITS +: CHAN_BITS]});
      end else if (cmd.emit) begin
        num[c] <= num[c] + {{(NUM_W-CHAN_BITS-1){delta[c][CHAN_BITS]}}, delta[c]};
      end
      if (cmd.div_start) begin
        rem[c] <= num[c][NUM_W-1:CHAN_BITS];
        quo[c] <= num[c][CHAN_BITS-1:0];
      end else if (cmd.div_step) begin
        rem[c] <= rem_next[c];
        quo[c] <= quo_next[c];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      color[c*CHAN_BITS +: CHAN_BITS] = quo[c];
    end
  end

endmodule

// File: rtl/line_rasterizer_color_interp_core.sv
// Line rasterizer with per-pixel RGBA interpolation: top level.
//
// Channels: cmd (sink) takes line loads (mode 0) and pixel requests (mode 1);
// pix (source) returns one pixel per request while a line is active.
// A transfer happens on a rising edge with valid and ready both high.
// A load is followed by the delta, setup and numerator steps and returns nothing.
// A pixel request passes from its transfer through the divider steps (2 quotient
// bits per cycle in four parallel channel lanes) and an emit step into the output
// register. The next request is taken only once the previous one has been emitted.
// A request with no active line is taken and returns nothing.
// A load during an active line drops the rest of that line.
// The output register holds a finished pixel while the next request is taken
// and divided; if pix stays stalled the block waits in its emit step with
// cmd.ready low until the register frees.
// Reset (rst, synchronous) returns to idle with no line active and pix.valid low.
module line_rasterizer_color_interp_core #(
  parameter int COORD_BITS = lrci_pkg::COORD_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  lrci_in_if.sink     cmd,
  lrci_out_if.source  pix
);
  import lrci_pkg::*;

  lrci_cmd_t                    ctl;
  lrci_stat_t                   stat;
  logic                         in_ready;
  logic                         out_free;
  logic signed [COORD_BITS-1:0] cur_x, cur_y;
  logic [COORD_BITS:0]          span;
  logic                         last_w;
  logic                         color_rev;
  logic [COLOR_BITS-1:0]        color_w;

  logic                         out_valid;
  logic signed [COORD_BITS-1:0] out_x, out_y;
  logic [COLOR_BITS-1:0]        out_color;
  logic                         out_we;
  logic                         out_last;

  assign out_free = !out_valid || pix.ready;

  lrci_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_mode  (cmd.mode),
    .out_free (out_free),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (ctl)
  );

  lrci_walk #(.COORD_BITS(COORD_BITS)) u_walk (
    .clk       (clk),
    .rst       (rst),
    .cmd       (ctl),
    .x_start   (cmd.x_start),
    .y_start   (cmd.y_start),
    .x_end     (cmd.x_end),
    .y_end     (cmd.y_end),
    .stat      (stat),
    .cur_x     (cur_x),
    .cur_y     (cur_y),
    .span      (span),
    .last      (last_w),
    .color_rev (color_rev)
  );

  lrci_color #(.COORD_BITS(COORD_BITS)) u_color (
    .clk          (clk),
    .cmd          (ctl),
    .first_color  (cmd.first_color),
    .second_color (cmd.second_color),
    .span         (span),
    .color_rev    (color_rev),
    .color        (color_w)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (pix.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_x     <= cur_x;
      out_y     <= cur_y;
      out_color <= color_w;
      out_we    <= !cur_x[COORD_BITS-1];
      out_last  <= last_w;
    end
  end

  assign cmd.ready        = in_ready;
  assign pix.valid        = out_valid;
  assign pix.pixel_x      = out_x;
  assign pix.pixel_y      = out_y;
  assign pix.pixel_color  = out_color;
  assign pix.write_enable = out_we;
  assign pix.last         = out_last;

endmodule

// File: rtl/lrci_checker.sv
// Port-level assertions for the line rasterizer, bound to the top level.
module lrci_checker #(
  parameter int COORD_BITS = lrci_pkg::COORD_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  cmd_valid,
  input logic                  cmd_ready,
  input logic                  cmd_mode,
  input logic                  pix_valid,
  input logic                  pix_ready,
  input logic [COORD_BITS-1:0] pix_x,
  input logic                  pix_we
);

  // a pending pixel stays until transfer
  a_pix_hold: assert property (@(posedge clk) disable iff (rst)
    pix_valid && !pix_ready |=> pix_valid)
    else $error("pixel dropped before transfer");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !pix_valid)
    else $error("pixel valid after reset");

  // line setup blocks the command channel for the next cycle
  a_load_busy: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && !cmd_mode |=> !cmd_ready)
    else $error("command taken during line setup");

  a_load_no_pixel: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready && !cmd_mode && !pix_valid |=> !pix_valid)
    else $error("line load produced a pixel");

  a_we_sign: assert property (@(posedge clk) disable iff (rst)
    pix_valid |-> (pix_we == !pix_x[COORD_BITS-1]))
    else $error("write enable disagrees with pixel x sign");

endmodule

bind line_rasterizer_color_interp_core lrci_checker #(.COORD_BITS(COORD_BITS)) u_lrci_checker (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .cmd_mode  (cmd.mode),
  .pix_valid (pix.valid),
  .pix_ready (pix.ready),
  .pix_x     (pix.pixel_x),
  .pix_we    (pix.write_enable)
);

// File: bench/tb_line_rasterizer_color_interp_core.sv
// Testbench for the line rasterizer: random loads and requests against a line-walk predictor.
module tb_line_rasterizer_color_interp_core;
  timeunit 1ns;
  timeprecision 1ps;
  import lrci_pkg::*;

  localparam int CW = COORD_BITS_DEF;
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;
  localparam int LIMIT = 400000;
  localparam int TAIL_CYCLES = 40;
  localparam int N_ITEMS = 1520;

  typedef struct {
    logic                   mode;
    logic signed [CW-1:0]   xs, ys, xe, ye;
    logic [COLOR_BITS-1:0]  sc, ec;
  } line_cmd_t;

  typedef struct {
    logic signed [CW-1:0]   x, y;
    logic [COLOR_BITS-1:0]  color;
    logic                   we;
    logic                   last_px;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lrci_in_if  cmd_if ();
  lrci_out_if pix_if ();

  line_rasterizer_color_interp_core u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .pix (pix_if)
  );

  line_cmd_t cmd_queue[$];
  pixel_t    expected_pixels[$];
  line_cmd_t cur_cmd;

  // line walk state
  int walk_x, walk_y, walk_dec, walk_k, walk_n, walk_adx, walk_ady, walk_dir;
  bit walk_steep, walk_active;
  logic [COLOR_BITS-1:0] col_from, col_to;

  int cmds_total, cmds_accepted, cycles;
  int lines_loaded, steep_lines, void_steps, offscreen_px, pixels_checked;
  int mismatches, hold_left;
  bit hold_done;
  logic calm;

  assign calm = (cmds_accepted >= 400) && (cmds_accepted < 700);

  function automatic logic [COLOR_BITS-1:0] mix_color(logic [COLOR_BITS-1:0] a,
                                                      logic [COLOR_BITS-1:0] b,
                                                      int k, int n);
    logic [COLOR_BITS-1:0] r;
    int s, e;
    r = '0;
    for (int c = 0; c < NUM_CHAN; c++) begin
      s = int'(a[c*CHAN_BITS +: CHAN_BITS]);
      e = int'(b[c*CHAN_BITS +: CHAN_BITS]);
      if (n != 0 && k <= n) begin
        r[c*CHAN_BITS +: CHAN_BITS] = CHAN_BITS'((s * (n - k) + e * k) / n);
      end else begin
        r[c*CHAN_BITS +: CHAN_BITS] = CHAN_BITS'(s);
      end
    end
    return r;
  endfunction

  task automatic raster_cmd(input line_cmd_t c);
    int x1, y1, x2, y2, t, dx, dy;
    logic [COLOR_BITS-1:0] c1, c2, tc;
    pixel_t p;
    if (c.mode == MODE_LOAD) begin
      x1 = int'(c.xs); y1 = int'(c.ys); x2 = int'(c.xe); y2 = int'(c.ye);
      c1 = c.sc; c2 = c.ec;
      if (x1 > x2) begin
        t = x1; x1 = x2; x2 = t;
        t = y1; y1 = y2; y2 = t;
        tc = c1; c1 = c2; c2 = tc;
      end
      dx = x2 - x1;
      dy = y2 - y1;
      walk_dir = (dy < 0) ? -1 : 1;
      walk_adx = dx;
      walk_ady = (dy < 0) ? -dy : dy;
      walk_k = 0;
      lines_loaded++;
      if (dx > 0 && dy > -dx && dy <= dx) begin
        walk_steep = 1'b0;
        walk_x = x1; walk_y = y1;
        col_from = c1; col_to = c2;
        walk_dec = walk_adx - 2 * walk_ady;
        walk_n = walk_adx;
      end else begin
        walk_steep = 1'b1;
        steep_lines++;
        if (y1 > y2) begin
          walk_x = x2; walk_y = y2;
          col_from = c2; col_to = c1;
        end else begin
          walk_x = x1; walk_y = y1;
          col_from = c1; col_to = c2;
        end
        walk_dec = walk_ady - 2 * walk_adx;
        walk_n = walk_ady;
      end
      walk_active = (walk_n != 0);
    end else if (!walk_active) begin
      void_steps++;
    end else begin
      p.x = CW'(walk_x);
      p.y = CW'(walk_y);
      p.color = mix_color(col_from, col_to, walk_k, walk_n);
      p.we = (walk_x >= 0);
      p.last_px = (walk_k + 1 >= walk_n);
      if (!p.we) offscreen_px++;
      expected_pixels.push_back(p);
      if (!walk_steep) begin
        walk_x++;
        if (walk_dec <= 0) begin
          walk_y += walk_dir;
          walk_dec += 2 * (walk_adx - walk_ady);
        end else begin
          walk_dec -= 2 * walk_ady;
        end
      end else begin
        walk_y++;
        if (walk_dec <= 0) begin
          walk_x += walk_dir;
          walk_dec += 2 * (walk_ady - walk_adx);
        end else begin
          walk_dec -= 2 * walk_adx;
        end
      end
      walk_k++;
      if (walk_k >= walk_n) walk_active = 1'b0;
    end
  endtask

  task automatic push_load(input int xs, ys, xe, ye, input logic [COLOR_BITS-1:0] sc, ec);
    line_cmd_t c;
    c.mode = MODE_LOAD;
    c.xs = CW'(xs); c.ys = CW'(ys); c.xe = CW'(xe); c.ye = CW'(ye);
    c.sc = sc; c.ec = ec;
    cmd_queue.push_back(c);
  endtask

  // step items carry junk in the unused fields
  task automatic push_steps(input int count);
    line_cmd_t c;
    for (int i = 0; i < count; i++) begin
      c.mode = MODE_STEP;
      c.xs = CW'($urandom); c.ys = CW'($urandom);
      c.xe = CW'($urandom); c.ye = CW'($urandom);
      c.sc = $urandom; c.ec = $urandom;
      cmd_queue.push_back(c);
    end
  endtask

  function automatic int clamp_coord(int v);
    if (v < -(1 << (CW - 1))) return -(1 << (CW - 1));
    if (v > (1 << (CW - 1)) - 1) return (1 << (CW - 1)) - 1;
    return v;
  endfunction

  function automatic int spread(int a, int b);
    int d;
    d = (a > b) ? a - b : b - a;
    return d;
  endfunction

  task automatic add_random_stimulus();
    int roll, bx, by, sp, x0, y0, x1, y1, n, steps;
    while (cmd_queue.size() < N_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 80) begin
        bx = ($urandom_range(0, 99) < 30) ? $urandom_range(0, 40) - 20
                                           : $urandom_range(0, 4095) - 2048;
        by = $urandom_range(0, 4095) - 2048;
        sp = ($urandom_range(0, 99) < 92) ? 15 : 300;
        x0 = clamp_coord(bx + $urandom_range(0, 2 * sp) - sp);
        y0 = clamp_coord(by + $urandom_range(0, 2 * sp) - sp);
        x1 = clamp_coord(bx + $urandom_range(0, 2 * sp) - sp);
        y1 = clamp_coord(by + $urandom_range(0, 2 * sp) - sp);
        n = (spread(x0, x1) > spread(y0, y1)) ? spread(x0, x1) : spread(y0, y1);
        roll = $urandom_range(0, 99);
        if (n > 40) steps = $urandom_range(1, 12);
        else if (roll < 12) steps = n + $urandom_range(1, 2);
        else if (roll < 22 && n > 1) steps = $urandom_range(1, n - 1);
        else steps = n;
        push_load(x0, y0, x1, y1, $urandom, $urandom);
        push_steps(steps);
      end else if (roll < 92) begin
        push_load($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        push_steps($urandom_range(0, 3));
      end else begin
        push_steps($urandom_range(1, 3));
      end
    end
  endtask

  initial begin
    forever #6 clk = ~clk;
  end

  // sender
  always @(posedge clk) begin
    if (rst) begin
      cmd_if.valid <= 1'b0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        raster_cmd(cur_cmd);
        cmds_accepted++;
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        if (cmd_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 25)) begin
          cur_cmd = cmd_queue.pop_front();
          cmd_if.valid        <= 1'b1;
          cmd_if.mode         <= cur_cmd.mode;
          cmd_if.x_start      <= cur_cmd.xs;
          cmd_if.y_start      <= cur_cmd.ys;
          cmd_if.x_end        <= cur_cmd.xe;
          cmd_if.y_end        <= cur_cmd.ye;
          cmd_if.first_color  <= cur_cmd.sc;
          cmd_if.second_color <= cur_cmd.ec;
        end else begin
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off once mid-run
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_done && cmds_accepted >= 900) begin
      hold_left <= 300;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    pixel_t exp_px;
    if (rst) begin
      pix_if.ready <= 1'b0;
    end else begin
      if (pix_if.valid && pix_if.ready) begin
        if (expected_pixels.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: unexpected pixel x=%0d y=%0d color=%08h we=%0b last=%0b",
                     pix_if.pixel_x, pix_if.pixel_y, pix_if.pixel_color,
                     pix_if.write_enable, pix_if.last);
        end else begin
          exp_px = expected_pixels.pop_front();
          pixels_checked++;
          if (pix_if.pixel_x !== exp_px.x || pix_if.pixel_y !== exp_px.y ||
              pix_if.pixel_color !== exp_px.color || pix_if.write_enable !== exp_px.we ||
              pix_if.last !== exp_px.last_px) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: exp x=%0d y=%0d color=%08h we=%0b last=%0b",
                       exp_px.x, exp_px.y, exp_px.color, exp_px.we, exp_px.last_px);
              $display("          got x=%0d y=%0d color=%08h we=%0b last=%0b",
                       pix_if.pixel_x, pix_if.pixel_y, pix_if.pixel_color,
                       pix_if.write_enable, pix_if.last);
            end
          end
        end
      end
      pix_if.ready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= 25);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    cmd_if.valid = 1'b0;
    cmd_if.mode = MODE_LOAD;
    cmd_if.x_start = '0;
    cmd_if.y_start = '0;
    cmd_if.x_end = '0;
    cmd_if.y_end = '0;
    cmd_if.first_color = '0;
    cmd_if.second_color = '0;
    pix_if.ready = 1'b0;
    walk_x = 0; walk_y = 0; walk_dec = 0; walk_k = 0; walk_n = 0;
    walk_adx = 0; walk_ady = 0; walk_dir = 1;
    walk_steep = 1'b0; walk_active = 1'b0;
    col_from = '0; col_to = '0;
    cmds_accepted = 0; cycles = 0; mismatches = 0; hold_done = 1'b0;
    lines_loaded = 0; steep_lines = 0; void_steps = 0; offscreen_px = 0;
    pixels_checked = 0;

    push_steps(1);                                       // request with no line
    push_load(5, 5, 5, 5, 32'h12345678, 32'h9abcdef0);  // zero length
    push_steps(1);
    push_load(-2048, -2048, 2047, 2047, 32'h00000000, 32'hffffffff);
    push_steps(3);
    push_load(2047, 2047, -2048, 2047, 32'hffffffff, 32'h00ff00ff);  // replaces busy line
    push_steps(2);
    push_load(0, 3, 1, 0, 32'h10203040, 32'hf0e0d0c0);  // y-major, walked downward
    push_steps(4);
    push_load(-1, 5, -1, 7, 32'h000000ff, 32'hff000000);  // vertical, offscreen x
    push_steps(2);
    push_load(0, 0, 2, -2, 32'h80808080, 32'h01010101);  // dy = -dx diagonal
    push_steps(2);
    add_random_stimulus();
    cmds_total = cmd_queue.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (cmds_accepted < cmds_total) @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    mismatches += expected_pixels.size();

    $display("Covered %0d commands: %0d line loads (%0d y-major), %0d requests with no line.",
             cmds_total, lines_loaded, steep_lines, void_steps);
    $display("Checked %0d pixels, %0d of them off-screen; %0d mismatches.",
             pixels_checked, offscreen_px, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/lrci_pkg.sv
rtl/lrci_if.sv
rtl/lrci_ctrl.sv
rtl/lrci_walk.sv
rtl/lrci_color.sv
rtl/line_rasterizer_color_interp_core.sv
rtl/lrci_checker.sv
bench/tb_line_rasterizer_color_interp_core.sv
